/* rtl/hpm_pkg.sv */
package hpm_pkg;

    // Coordinate and fixed-point format
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;

    // Datapath widths
    localparam int COEF_W    = 32;
    localparam int PROD_W    = COEF_W + COORD_BITS + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int MAG_W     = SUM_W;
    localparam int REM_W     = MAG_W + 1;
    localparam int QUO_W     = 32;
    localparam int DIV_STEPS = QUO_W;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LAST   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY   = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

    localparam logic [QUO_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [QUO_W-1:0] Q_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [11:0]        col;
        logic [11:0]        row;
        logic signed [31:0] height_in;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
    } pix_in_t;

    typedef struct packed {
        logic signed [31:0] mapped_x;
        logic signed [31:0] mapped_y;
        logic signed [31:0] height_out;
        logic [7:0]         red_out;
        logic [7:0]         green_out;
        logic [7:0]         blue_out;
        logic [1:0]         status;
    } pix_out_t;

    // Fields that ride along with the division
    typedef struct packed {
        logic signed [31:0] height;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               zero_den;
        logic               num_neg_x;
        logic               num_neg_y;
        logic               den_neg;
        logic               ovf_x;
        logic               ovf_y;
    } side_t;

endpackage

/* rtl/homography_pixel_mapper_top.sv */
// An accepted input beat passes multiply, sum, sign/range check,
// 32 divider steps and saturation on its way to its result beat.
// Throughput: one pixel per cycle while the output beat is not held; the two
// restoring dividers are fully pipelined, one quotient bit per stage.
// Reset (rst_n low, asynchronous) loads the identity matrix, clears gray mode
// and empties the pipeline.
module homography_pixel_mapper_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hpm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hpm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  hpm_pkg::pix_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output hpm_pkg::pix_out_t             out_data
);
    import hpm_pkg::*;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] qd;
    } div_t;

    // Configuration registers
    logic [CFG_W-1:0]  pair_a_reg, pair_b_reg, pair_c_reg, pair_d_reg;
    logic [COEF_W-1:0] last_reg;
    logic              gray_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_a_reg <= CFG_W'(64'd1) << (32 + FRAC_BITS);
            pair_b_reg <= '0;
            pair_c_reg <= CFG_W'(64'd1) << (32 + FRAC_BITS);
            pair_d_reg <= '0;
            last_reg   <= COEF_W'(32'd1) << FRAC_BITS;
            gray_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PAIR_A: pair_a_reg <= cfg_data;
                REG_PAIR_B: pair_b_reg <= cfg_data;
                REG_PAIR_C: pair_c_reg <= cfg_data;
                REG_PAIR_D: pair_d_reg <= cfg_data;
                REG_LAST:   last_reg   <= cfg_data[COEF_W-1:0];
                REG_GRAY:   gray_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Global advance: the whole pipe moves unless the output beat is held
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    logic signed [COEF_W-1:0] h00, h01, h02, h10, h11, h12, h20, h21, h22;
    assign h00 = signed'(pair_a_reg[63:32]);
    assign h01 = signed'(pair_a_reg[31:0]);
    assign h02 = signed'(pair_b_reg[63:32]);
    assign h10 = signed'(pair_b_reg[31:0]);
    assign h11 = signed'(pair_c_reg[63:32]);
    assign h12 = signed'(pair_c_reg[31:0]);
    assign h20 = signed'(pair_d_reg[63:32]);
    assign h21 = signed'(pair_d_reg[31:0]);
    assign h22 = signed'(last_reg);

    logic signed [COORD_BITS:0] xs, ys;
    assign xs = signed'({1'b0, in_data.col[COORD_BITS-1:0]});
    assign ys = signed'({1'b0, in_data.row[COORD_BITS-1:0]});

    // Stage 1: products
    logic                     v1_reg;
    logic signed [PROD_W-1:0] p00_reg, p01_reg, p10_reg, p11_reg, p20_reg, p21_reg;
    logic signed [COEF_W-1:0] c02_reg, c12_reg, c22_reg;
    side_t                    s1_reg;
    side_t                    s1_next;

    // Pick the colors for this beat, clear the flags filled in later
    always_comb
    begin
        s1_next        = '0;
        s1_next.height = in_data.height_in;
        s1_next.red    = in_data.red_in;
        s1_next.green  = gray_reg ? in_data.red_in : in_data.green_in;
        s1_next.blue   = gray_reg ? in_data.red_in : in_data.blue_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p00_reg <= PROD_W'(h00) * PROD_W'(xs);
            p01_reg <= PROD_W'(h01) * PROD_W'(ys);
            p10_reg <= PROD_W'(h10) * PROD_W'(xs);
            p11_reg <= PROD_W'(h11) * PROD_W'(ys);
            p20_reg <= PROD_W'(h20) * PROD_W'(xs);
            p21_reg <= PROD_W'(h21) * PROD_W'(ys);
            c02_reg <= h02;
            c12_reg <= h12;
            c22_reg <= h22;
            s1_reg  <= s1_next;
        end
    end

    // Stage 2: dot product sums
    logic                    v2_reg;
    logic signed [SUM_W-1:0] nx_reg, ny_reg, dz_reg;
    side_t                   s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx_reg <= SUM_W'(p00_reg) + SUM_W'(p01_reg) + SUM_W'(c02_reg);
            ny_reg <= SUM_W'(p10_reg) + SUM_W'(p11_reg) + SUM_W'(c12_reg);
            dz_reg <= SUM_W'(p20_reg) + SUM_W'(p21_reg) + SUM_W'(c22_reg);
            s2_reg <= s1_reg;
        end
    end

    // Stage 3: magnitudes, signs, zero and range check, divider seed
    localparam int SH_W = MAG_W + 32 - FRAC_BITS;
    localparam int DF_W = MAG_W + FRAC_BITS;

    logic [MAG_W-1:0] ux, uy, ud;
    logic [SH_W-1:0]  ud_sh;
    logic [DF_W-1:0]  dfx, dfy;
    side_t            s3_next;

    always_comb
    begin
        ux    = nx_reg[SUM_W-1] ? MAG_W'(-nx_reg) : MAG_W'(nx_reg);
        uy    = ny_reg[SUM_W-1] ? MAG_W'(-ny_reg) : MAG_W'(ny_reg);
        ud    = dz_reg[SUM_W-1] ? MAG_W'(-dz_reg) : MAG_W'(dz_reg);
        ud_sh = {ud, {(32 - FRAC_BITS){1'b0}}};
        dfx   = {ux, {FRAC_BITS{1'b0}}};
        dfy   = {uy, {FRAC_BITS{1'b0}}};
        s3_next           = s2_reg;
        s3_next.zero_den  = (dz_reg == '0);
        s3_next.num_neg_x = nx_reg[SUM_W-1];
        s3_next.num_neg_y = ny_reg[SUM_W-1];
        s3_next.den_neg   = dz_reg[SUM_W-1];
        s3_next.ovf_x     = ({{(32 - FRAC_BITS){1'b0}}, ux} >= ud_sh);
        s3_next.ovf_y     = ({{(32 - FRAC_BITS){1'b0}}, uy} >= ud_sh);
    end

    // Divider pipe: index 0 is the seed, each step resolves one quotient bit
    logic             dv_reg  [0:DIV_STEPS];
    side_t            ds_reg  [0:DIV_STEPS];
    logic [MAG_W-1:0] dd_reg  [0:DIV_STEPS];
    div_t             dx_reg  [0:DIV_STEPS];
    div_t             dy_reg  [0:DIV_STEPS];

    function automatic div_t div_step(input div_t cur, input logic [MAG_W-1:0] den);
        logic [REM_W-1:0] trial;
        div_t             res;
        trial = {cur.rem[REM_W-2:0], cur.qd[QUO_W-1]};
        if (trial >= REM_W'(den))
        begin
            res.rem = trial - REM_W'(den);
            res.qd  = {cur.qd[QUO_W-2:0], 1'b1};
        end
        else
        begin
            res.rem = trial;
            res.qd  = {cur.qd[QUO_W-2:0], 1'b0};
        end
        return res;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg[0] <= 1'b0;
        else if (adv)
            dv_reg[0] <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ds_reg[0]     <= s3_next;
            dd_reg[0]     <= ud;
            dx_reg[0].rem <= REM_W'(dfx[DF_W-1:32]);
            dx_reg[0].qd  <= dfx[31:0];
            dy_reg[0].rem <= REM_W'(dfy[DF_W-1:32]);
            dy_reg[0].qd  <= dfy[31:0];
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[k+1] <= 1'b0;
            else if (adv)
                dv_reg[k+1] <= dv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ds_reg[k+1] <= ds_reg[k];
                dd_reg[k+1] <= dd_reg[k];
                dx_reg[k+1] <= div_step(dx_reg[k], dd_reg[k]);
                dy_reg[k+1] <= div_step(dy_reg[k], dd_reg[k]);
            end
        end
    end

    // Output stage: sign, saturation, status
    function automatic logic [QUO_W:0] finish(input logic [QUO_W-1:0] q, input logic neg,
                                              input logic ovf);
        logic [QUO_W-1:0] lim;
        lim = neg ? Q_MIN : Q_MAX;
        if (ovf || (q > lim))
            return {1'b1, lim};
        else
            return {1'b0, neg ? (QUO_W'(0) - q) : q};
    endfunction

    side_t            sf;
    logic [QUO_W:0]   fx, fy;
    pix_out_t         out_next;
    logic             out_valid_reg;
    pix_out_t         out_reg;

    always_comb
    begin
        sf = ds_reg[DIV_STEPS];
        fx = finish(dx_reg[DIV_STEPS].qd, sf.num_neg_x ^ sf.den_neg, sf.ovf_x);
        fy = finish(dy_reg[DIV_STEPS].qd, sf.num_neg_y ^ sf.den_neg, sf.ovf_y);
        out_next.height_out = sf.height;
        out_next.red_out    = sf.red;
        out_next.green_out  = sf.green;
        out_next.blue_out   = sf.blue;
        if (sf.zero_den)
        begin
            out_next.mapped_x = signed'(sf.num_neg_x ? Q_MIN : Q_MAX);
            out_next.mapped_y = signed'(sf.num_neg_y ? Q_MIN : Q_MAX);
            out_next.status   = ST_ZERO_DEN;
        end
        else
        begin
            out_next.mapped_x = signed'(fx[QUO_W-1:0]);
            out_next.mapped_y = signed'(fy[QUO_W-1:0]);
            out_next.status   = (fx[QUO_W] || fy[QUO_W]) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_reg[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Checks
    a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == ST_ZERO_DEN) |->
            ((out_data.mapped_x == Q_MAX || out_data.mapped_x == Q_MIN) &&
             (out_data.mapped_y == Q_MAX || out_data.mapped_y == Q_MIN)))
        else $error("zero denominator result not saturated");

    a_no_code3: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status <= ST_SAT))
        else $error("reserved status code produced");

    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> ($stable(dv_reg[DIV_STEPS]) && $stable(v1_reg)))
        else $error("pipeline moved while output held");

    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid_reg && out_stall))
        else $error("input stall not tied to held output");

endmodule

/* tb/tb_homography_pixel_mapper_top.sv */
`timescale 1ns / 1ps

module tb_homography_pixel_mapper_top;
    import hpm_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int DRAIN_CYCLES = 48;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    pix_in_t              in_data;
    logic                 out_valid;
    logic                 out_stall;
    pix_out_t             out_data;

    // Matrix and mode as the block should hold them
    logic [63:0] pair_a_q;
    logic [63:0] pair_b_q;
    logic [63:0] pair_c_q;
    logic [63:0] pair_d_q;
    logic [31:0] h22_q;
    logic        gray_q;

    pix_in_t  pixel_queue[$];
    pix_out_t mapped_queue[$];

    int  sender_idle_pct;
    int  recv_idle_pct;
    bit  in_taken;
    int  error_count;
    int  pixels_sent;
    int  pixels_checked;
    int  zero_den_seen;
    int  sat_seen;
    int  cycle_count;

    homography_pixel_mapper_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Signed Q16.16 quotient of n by d, truncated toward zero, saturated
    function automatic logic [31:0] fixed_quotient(longint n, longint d, inout bit sat);
        bit                neg;
        longint unsigned   un;
        longint unsigned   ud;
        longint unsigned   q;
        longint unsigned   r;
        longint unsigned   lim;
        neg = (n < 0) != (d < 0);
        un  = (n < 0) ? longint'(-n) : n;
        ud  = (d < 0) ? longint'(-d) : d;
        q   = un / ud;
        r   = un % ud;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (q > 64'hFFFF_FFFF)
        begin
            sat = 1'b1;
            return neg ? Q_MIN : Q_MAX;
        end
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= ud)
            begin
                r = r - ud;
                q = q | 64'd1;
            end
        end
        if (q > lim)
        begin
            sat = 1'b1;
            return neg ? Q_MIN : Q_MAX;
        end
        return neg ? 32'(64'd0 - q) : q[31:0];
    endfunction

    // Map one pixel through the current matrix
    function automatic pix_out_t map_pixel(pix_in_t p);
        pix_out_t o;
        longint   x;
        longint   y;
        longint   nx;
        longint   ny;
        longint   dz;
        longint   h00, h01, h02, h10, h11, h12, h20, h21, h22;
        bit       sat;
        x   = p.col;
        y   = p.row;
        h00 = $signed(pair_a_q[63:32]);
        h01 = $signed(pair_a_q[31:0]);
        h02 = $signed(pair_b_q[63:32]);
        h10 = $signed(pair_b_q[31:0]);
        h11 = $signed(pair_c_q[63:32]);
        h12 = $signed(pair_c_q[31:0]);
        h20 = $signed(pair_d_q[63:32]);
        h21 = $signed(pair_d_q[31:0]);
        h22 = $signed(h22_q);
        nx  = h00 * x + h01 * y + h02;
        ny  = h10 * x + h11 * y + h12;
        dz  = h20 * x + h21 * y + h22;
        sat = 1'b0;
        if (dz == 0)
        begin
            o.mapped_x = (nx < 0) ? Q_MIN : Q_MAX;
            o.mapped_y = (ny < 0) ? Q_MIN : Q_MAX;
            o.status   = ST_ZERO_DEN;
        end
        else
        begin
            o.mapped_x = fixed_quotient(nx, dz, sat);
            o.mapped_y = fixed_quotient(ny, dz, sat);
            o.status   = sat ? ST_SAT : ST_OK;
        end
        o.height_out = p.height_in;
        o.red_out    = p.red_in;
        o.green_out  = gray_q ? p.red_in : p.green_in;
        o.blue_out   = gray_q ? p.red_in : p.blue_in;
        return o;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Track registers, predict accepted pixels, check result beats
    always @(posedge clk)
    begin
        pix_out_t exp_o;
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PAIR_A: pair_a_q = cfg_data;
                    REG_PAIR_B: pair_b_q = cfg_data;
                    REG_PAIR_C: pair_c_q = cfg_data;
                    REG_PAIR_D: pair_d_q = cfg_data;
                    REG_LAST:   h22_q    = cfg_data[31:0];
                    REG_GRAY:   gray_q   = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                in_taken = 1'b1;
                mapped_queue.push_back(map_pixel(in_data));
            end
            if (out_valid && !out_stall)
            begin
                if (mapped_queue.size() == 0)
                begin
                    $error("result beat with no pixel outstanding");
                    error_count++;
                end
                else
                begin
                    exp_o = mapped_queue.pop_front();
                    check_field("mapped_x", exp_o.mapped_x, out_data.mapped_x);
                    check_field("mapped_y", exp_o.mapped_y, out_data.mapped_y);
                    check_field("height_out", exp_o.height_out, out_data.height_out);
                    check_field("red_out", exp_o.red_out, out_data.red_out);
                    check_field("green_out", exp_o.green_out, out_data.green_out);
                    check_field("blue_out", exp_o.blue_out, out_data.blue_out);
                    check_field("status", exp_o.status, out_data.status);
                    pixels_checked++;
                    if (exp_o.status == ST_ZERO_DEN)
                        zero_den_seen++;
                    if (exp_o.status == ST_SAT)
                        sat_seen++;
                end
            end
        end
    end

    // Drive input beats and receiver stall on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pixel_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    in_data  <= pixel_queue.pop_front();
                    in_valid <= 1'b1;
                    pixels_sent++;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", mapped_queue.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_matrix(logic [63:0] a, logic [63:0] b, logic [63:0] c,
                               logic [63:0] d, logic [31:0] h22, logic gray);
        write_reg(REG_PAIR_A, a);
        write_reg(REG_PAIR_B, b);
        write_reg(REG_PAIR_C, c);
        write_reg(REG_PAIR_D, d);
        write_reg(REG_LAST, {32'hDEAD_BEEF, h22});
        write_reg(REG_GRAY, {$urandom, 31'($urandom_range(0, 32'h7FFF_FFFF)), gray});
    endtask

    // Hold off until every pixel is out and the pipeline is empty
    task automatic drain();
        while (pixel_queue.size() > 0 || in_valid || mapped_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic pix_in_t make_pixel(logic [11:0] c, logic [11:0] r, logic [31:0] h,
                                           logic [7:0] rd, logic [7:0] gr, logic [7:0] bl);
        pix_in_t p;
        p.col       = c;
        p.row       = r;
        p.height_in = h;
        p.red_in    = rd;
        p.green_in  = gr;
        p.blue_in   = bl;
        return p;
    endfunction

    function automatic pix_in_t rand_pixel();
        return make_pixel(12'($urandom), 12'($urandom), $urandom,
                          8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // Mix of full-range, small, zero and unity coefficients
    function automatic logic [31:0] rand_coef(int span);
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'h0001_0000;
            2: return 32'h0;
            default: return $urandom_range(0, 2 * span) - span;
        endcase
    endfunction

    task automatic load_random_matrix();
        logic [31:0] h20;
        logic [31:0] h21;
        logic [31:0] h22;
        h20 = rand_coef(32'h100);
        h21 = rand_coef(32'h100);
        h22 = rand_coef(32'h40000);
        // Sometimes make the denominator vanish everywhere
        if ($urandom_range(0, 7) == 0)
        begin
            h20 = 32'h0;
            h21 = 32'h0;
            h22 = 32'h0;
        end
        load_matrix({rand_coef(32'h40000), rand_coef(32'h40000)},
                    {rand_coef(32'h4000000), rand_coef(32'h40000)},
                    {rand_coef(32'h40000), rand_coef(32'h4000000)},
                    {h20, h21}, h22, $urandom_range(0, 1));
    endtask

    task automatic random_block(int count);
        for (int i = 0; i < count; i++)
            pixel_queue.push_back(rand_pixel());
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_PAIR_A;
        cfg_data        = '0;
        in_valid        = 1'b0;
        in_data         = '0;
        out_stall       = 1'b0;
        in_taken        = 1'b0;
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        error_count     = 0;
        pixels_sent     = 0;
        pixels_checked  = 0;
        zero_den_seen   = 0;
        sat_seen        = 0;
        cycle_count     = 0;
        pair_a_q        = 64'h0001_0000_0000_0000;
        pair_b_q        = 64'h0;
        pair_c_q        = 64'h0001_0000_0000_0000;
        pair_d_q        = 64'h0;
        h22_q           = 32'h0001_0000;
        gray_q          = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Identity after reset: corners, field extremes
        pixel_queue.push_back(make_pixel(12'd0, 12'd0, 32'h0, 8'h00, 8'h00, 8'h00));
        pixel_queue.push_back(make_pixel(12'hFFF, 12'hFFF, 32'h7FFF_FFFF, 8'hFF, 8'hFF, 8'hFF));
        pixel_queue.push_back(make_pixel(12'hFFF, 12'd0, 32'h8000_0000, 8'hA5, 8'h5A, 8'h0F));
        pixel_queue.push_back(make_pixel(12'd0, 12'hFFF, 32'hFFFF_FFFF, 8'h01, 8'h80, 8'hF0));
        drain();

        // Unknown register indexes leave the matrix alone
        write_reg(REG_SPARE_6, '1);
        write_reg(REG_SPARE_7, '1);
        pixel_queue.push_back(make_pixel(12'd17, 12'd99, 32'h1234_5678, 8'h11, 8'h22, 8'h33));
        drain();

        // Zero denominator, numerators of both signs, gray on
        load_matrix({32'h0001_0000, 32'hFFFF_0000}, {32'h0, 32'hFFFF_0000},
                    {32'h0001_0000, 32'h0}, 64'h0, 32'h0, 1'b1);
        pixel_queue.push_back(make_pixel(12'd0, 12'd0, 32'h1, 8'h77, 8'h00, 8'hFF));
        pixel_queue.push_back(make_pixel(12'd5, 12'd9, 32'h2, 8'h80, 8'h12, 8'h34));
        pixel_queue.push_back(make_pixel(12'd9, 12'd5, 32'h3, 8'hFF, 8'h56, 8'h78));
        pixel_queue.push_back(make_pixel(12'hFFF, 12'hFFF, 32'h4, 8'h00, 8'hFF, 8'hFF));
        drain();

        // Saturation: extreme coefficients over a tiny denominator
        load_matrix({32'h7FFF_FFFF, 32'h8000_0000}, {32'h7FFF_FFFF, 32'h8000_0000},
                    {32'h7FFF_FFFF, 32'h8000_0000}, {32'h0, 32'h0}, 32'h0000_0001, 1'b0);
        pixel_queue.push_back(make_pixel(12'd0, 12'd0, 32'h5, 8'h01, 8'h02, 8'h03));
        pixel_queue.push_back(make_pixel(12'hFFF, 12'd0, 32'h6, 8'h04, 8'h05, 8'h06));
        pixel_queue.push_back(make_pixel(12'd0, 12'hFFF, 32'h7, 8'h07, 8'h08, 8'h09));
        pixel_queue.push_back(make_pixel(12'hFFF, 12'hFFF, 32'h8, 8'h0A, 8'h0B, 8'h0C));
        drain();

        // Negative denominator, extreme last entry
        load_matrix({32'h0002_0000, 32'h0}, {32'h0, 32'h0},
                    {32'h0003_0000, 32'h0}, {32'hFFFF_FFFF, 32'h0000_0001},
                    32'h8000_0000, 1'b0);
        pixel_queue.push_back(make_pixel(12'd100, 12'd200, 32'h9, 8'h10, 8'h20, 8'h30));
        pixel_queue.push_back(make_pixel(12'hFFF, 12'd1, 32'hA, 8'h40, 8'h50, 8'h60));
        drain();
        load_matrix('1, '1, '1, '1, 32'h7FFF_FFFF, 1'b1);
        pixel_queue.push_back(make_pixel(12'd3, 12'd4, 32'hB, 8'hC3, 8'h3C, 8'h99));
        pixel_queue.push_back(make_pixel(12'hFFF, 12'hFFF, 32'hC, 8'h55, 8'hAA, 8'h66));
        drain();

        // Random traffic: busy sender and slow receiver, then swapped, then none
        for (int ph = 0; ph < 3; ph++)
        begin
            sender_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 87 : 0;
            recv_idle_pct   = (ph == 0) ? 87 : (ph == 1) ? 32 : 0;
            for (int seg = 0; seg < 4; seg++)
            begin
                load_random_matrix();
                random_block(70);
                // Sender pauses until all outstanding results are back
                if (seg == 1)
                    drain();
                random_block(63);
                drain();
            end
        end

        $display("covered %0d pixels (%0d zero denominator, %0d saturated) over",
                 pixels_checked, zero_den_seen, sat_seen);
        $display("many matrices, both color modes and three stall patterns");
        if (error_count == 0 && mapped_queue.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
